// ===== hdl/fmtsc_pkg.sv =====
`timescale 1ns / 1ps

package fmtsc_pkg;

   // Frame and field sizes
   localparam int FRAME_BITS = 45;
   localparam int FRAME_W    = 64;
   localparam int CNT_W      = $clog2(FRAME_BITS + 1);
   localparam int CMD_W      = 3;
   localparam int FREQ_W     = 21;
   localparam int VOL_W      = 4;
   localparam int STAT_W     = 8;
   localparam int KIND_W     = 2;
   localparam int IDX_W      = 6;

   // Divide by 160: shift right by 5, then multiply by the reciprocal of 5
   localparam int DIV_SHIFT   = 5;
   localparam int QUO_W       = FREQ_W - DIV_SHIFT;
   localparam int PROD_W      = 2 * QUO_W;
   localparam int RECIP_SHIFT = 18;
   localparam int STEP_W      = PROD_W - RECIP_SHIFT;
   localparam logic [QUO_W-1:0] RECIP_FIVE = QUO_W'(52429);

   // Tuning word and frame template
   localparam int WORD_W = 16;
   localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(8800);
   localparam logic [WORD_W-1:0] WORD_BASE = 16'h4d1c;
   localparam logic [FRAME_W-1:0] FRAME_TEMPLATE = 64'hc480402c10080000;
   localparam int WORD_LO_POS = 47;
   localparam int WORD_HI_POS = 38;
   localparam int STEREO_POS  = 31;

   // Status codes reported by the card
   localparam logic [STAT_W-1:0] STAT_STEREO = 8'hcf;
   localparam logic [STAT_W-1:0] STAT_MONO_A = 8'hdf;
   localparam logic [STAT_W-1:0] STAT_MONO_B = 8'hef;

   // Queue depths
   localparam int JOB_DEPTH   = 2;
   localparam int JOB_PTR_W   = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W   = $clog2(JOB_DEPTH + 1);
   localparam int RES_DEPTH   = 2;
   localparam int RES_PTR_W   = $clog2(RES_DEPTH);
   localparam int RES_CNT_W   = $clog2(RES_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_SET_FREQ   = 3'd0,
      CMD_SET_VOLUME = 3'd1,
      CMD_MUTE       = 3'd2,
      CMD_UNMUTE     = 3'd3,
      CMD_SET_STEREO = 3'd4,
      CMD_CLASSIFY   = 3'd5
   } command_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_BIT     = 2'd0,
      KIND_SILENCE = 2'd1,
      KIND_VOLUME  = 2'd2,
      KIND_STATUS  = 2'd3
   } kind_type;

   // The closing result of a job (sound or status)
   typedef struct packed {
      kind_type          kind;
      logic [VOL_W-1:0]  vcode;
      logic              sig;
      logic              st;
   } tail_type;

   // One job passed from the front to the back
   typedef struct packed {
      logic                is_tune;
      logic [FRAME_W-1:0]  frame;
      tail_type            tail;
   } job_type;

   typedef struct packed {
      kind_type          kind;
      logic [IDX_W-1:0]  bit_index;
      logic              serial_bit;
      logic [VOL_W-1:0]  volume_code;
      logic              signal_present;
      logic              stereo_detected;
      logic              last;
   } result_type;

   // Silence when muted or at level zero, otherwise write level minus one
   function automatic tail_type sound_tail(logic muted, logic [VOL_W-1:0] level);
      tail_type t;
      t = '0;
      if (muted || (level == '0)) begin
         t.kind = KIND_SILENCE;
      end else begin
         t.kind  = KIND_VOLUME;
         t.vcode = level - VOL_W'(1);
      end
      return t;
   endfunction

   // Compare two status samples
   function automatic tail_type status_tail(logic [STAT_W-1:0] s1, logic [STAT_W-1:0] s2);
      tail_type t;
      logic     same;
      t      = '0;
      same   = (s1 == s2);
      t.kind = KIND_STATUS;
      t.sig  = same && ((s1 == STAT_STEREO) || (s1 == STAT_MONO_A) || (s1 == STAT_MONO_B));
      t.st   = same && (s1 == STAT_STEREO);
      return t;
   endfunction

endpackage

// ===== hdl/fmtsc_front.sv =====
`timescale 1ns / 1ps

module fmtsc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [fmtsc_pkg::CMD_W-1:0]       req_command,
   input  logic [fmtsc_pkg::FREQ_W-1:0]      req_frequency,
   input  logic [fmtsc_pkg::VOL_W-1:0]       req_volume,
   input  logic                              req_stereo_mode,
   input  logic [fmtsc_pkg::STAT_W-1:0]      req_status_first,
   input  logic [fmtsc_pkg::STAT_W-1:0]      req_status_second,
   output logic                              job_valid,
   input  logic                              job_ready,
   output fmtsc_pkg::job_type                job_data
);

   typedef struct packed {
      logic                          is_tune;
      logic [fmtsc_pkg::QUO_W-1:0]   quo;
      logic                          stereo;
      fmtsc_pkg::tail_type           tail;
   } stage_a_type;

   typedef struct packed {
      logic                          is_tune;
      logic [fmtsc_pkg::STEP_W-1:0]  steps;
      logic                          stereo;
      fmtsc_pkg::tail_type           tail;
   } stage_b_type;

   // Card state
   logic [fmtsc_pkg::VOL_W-1:0]  volume_level_ff, volume_level_in;
   logic                         muted_ff, muted_in;
   logic                         stereo_ff, stereo_in;
   logic [fmtsc_pkg::FREQ_W-1:0] tuned_freq_ff, tuned_freq_in;

   // Pipeline stages
   logic         a_valid_ff, a_valid_in;
   stage_a_type  a_ff, a_in;
   logic         b_valid_ff, b_valid_in;
   stage_b_type  b_ff, b_in;

   logic         accept;
   logic         advance_a;
   logic         advance_b;
   logic         cls_valid;
   stage_a_type  cls;
   fmtsc_pkg::command_type cmd;

   logic [fmtsc_pkg::PROD_W-1:0] product;
   logic [fmtsc_pkg::STEP_W-1:0] steps_clamped;
   logic [fmtsc_pkg::WORD_W-1:0] word;

   // Stall handshake: move forward whenever the next stage has room
   assign advance_b = !b_valid_ff || job_ready;
   assign advance_a = !a_valid_ff || advance_b;
   assign req_full  = !advance_a;
   assign accept    = req_push && !req_full;
   assign cmd       = fmtsc_pkg::command_type'(req_command);

   // Classify the item and update the card state
   always_comb begin
      volume_level_in = volume_level_ff;
      muted_in        = muted_ff;
      stereo_in       = stereo_ff;
      tuned_freq_in   = tuned_freq_ff;
      cls_valid       = 1'b0;
      cls             = '0;
      unique case (cmd)
         fmtsc_pkg::CMD_SET_FREQ: begin
            tuned_freq_in = req_frequency;
            cls_valid     = (req_frequency != '0);
            cls.is_tune   = 1'b1;
            cls.quo       = req_frequency[fmtsc_pkg::FREQ_W-1:fmtsc_pkg::DIV_SHIFT];
            cls.stereo    = stereo_ff;
            cls.tail      = fmtsc_pkg::sound_tail(muted_ff, volume_level_ff);
         end
         fmtsc_pkg::CMD_SET_VOLUME: begin
            volume_level_in = req_volume;
            cls_valid       = !muted_ff;
            cls.tail        = fmtsc_pkg::sound_tail(1'b0, req_volume);
         end
         fmtsc_pkg::CMD_MUTE: begin
            muted_in  = 1'b1;
            cls_valid = 1'b1;
            cls.tail  = fmtsc_pkg::sound_tail(1'b1, volume_level_ff);
         end
         fmtsc_pkg::CMD_UNMUTE: begin
            muted_in  = 1'b0;
            cls_valid = 1'b1;
            cls.tail  = fmtsc_pkg::sound_tail(1'b0, volume_level_ff);
         end
         fmtsc_pkg::CMD_SET_STEREO: begin
            stereo_in   = req_stereo_mode;
            cls_valid   = (tuned_freq_ff != '0);
            cls.is_tune = 1'b1;
            cls.quo     = tuned_freq_ff[fmtsc_pkg::FREQ_W-1:fmtsc_pkg::DIV_SHIFT];
            cls.stereo  = req_stereo_mode;
            cls.tail    = fmtsc_pkg::sound_tail(muted_ff, volume_level_ff);
         end
         fmtsc_pkg::CMD_CLASSIFY: begin
            cls_valid = 1'b1;
            cls.tail  = fmtsc_pkg::status_tail(req_status_first, req_status_second);
         end
         default: begin
         end
      endcase
      if (!accept) begin
         volume_level_in = volume_level_ff;
         muted_in        = muted_ff;
         stereo_in       = stereo_ff;
         tuned_freq_in   = tuned_freq_ff;
      end
   end

   // Stage A: hold classified item; stage B: hold step count from the multiplier
   always_comb begin
      a_valid_in = a_valid_ff;
      a_in       = a_ff;
      if (advance_a) begin
         a_valid_in = accept && cls_valid;
         a_in       = cls;
      end
      product    = fmtsc_pkg::PROD_W'(a_ff.quo) * fmtsc_pkg::PROD_W'(fmtsc_pkg::RECIP_FIVE);
      b_valid_in = b_valid_ff;
      b_in       = b_ff;
      if (advance_b) begin
         b_valid_in   = a_valid_ff;
         b_in.is_tune = a_ff.is_tune;
         b_in.steps   = product[fmtsc_pkg::PROD_W-1:fmtsc_pkg::RECIP_SHIFT];
         b_in.stereo  = a_ff.stereo;
         b_in.tail    = a_ff.tail;
      end
   end

   // Build the tuning word and frame
   always_comb begin
      steps_clamped = (b_ff.steps < fmtsc_pkg::STEP_MIN) ? fmtsc_pkg::STEP_MIN : b_ff.steps;
      word = fmtsc_pkg::WORD_W'({steps_clamped - fmtsc_pkg::STEP_MIN, 1'b0})
           + fmtsc_pkg::WORD_BASE;
      job_data         = '0;
      job_data.is_tune = b_ff.is_tune;
      job_data.tail    = b_ff.tail;
      if (b_ff.is_tune) begin
         job_data.frame = fmtsc_pkg::FRAME_TEMPLATE
            ^ (fmtsc_pkg::FRAME_W'(word[7:0]) << fmtsc_pkg::WORD_LO_POS)
            ^ (fmtsc_pkg::FRAME_W'(word[15:8]) << fmtsc_pkg::WORD_HI_POS)
            ^ (fmtsc_pkg::FRAME_W'(b_ff.stereo) << fmtsc_pkg::STEREO_POS);
      end
   end

   assign job_valid = b_valid_ff;

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_level_ff <= '0;
         muted_ff        <= 1'b0;
         stereo_ff       <= 1'b1;
         tuned_freq_ff   <= '0;
         a_valid_ff      <= 1'b0;
         b_valid_ff      <= 1'b0;
      end else begin
         volume_level_ff <= volume_level_in;
         muted_ff        <= muted_in;
         stereo_ff       <= stereo_in;
         tuned_freq_ff   <= tuned_freq_in;
         a_valid_ff      <= a_valid_in;
         b_valid_ff      <= b_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

// ===== hdl/fmtsc_job_queue.sv =====
`timescale 1ns / 1ps

module fmtsc_job_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  fmtsc_pkg::job_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output fmtsc_pkg::job_type  pop_data
);

   fmtsc_pkg::job_type                 mem_ff [fmtsc_pkg::JOB_DEPTH];
   logic [fmtsc_pkg::JOB_PTR_W-1:0]    wr_ff, wr_in;
   logic [fmtsc_pkg::JOB_PTR_W-1:0]    rd_ff, rd_in;
   logic [fmtsc_pkg::JOB_CNT_W-1:0]    count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != fmtsc_pkg::JOB_CNT_W'(fmtsc_pkg::JOB_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and count
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == fmtsc_pkg::JOB_PTR_W'(fmtsc_pkg::JOB_DEPTH - 1)) ? '0
               : wr_ff + fmtsc_pkg::JOB_PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == fmtsc_pkg::JOB_PTR_W'(fmtsc_pkg::JOB_DEPTH - 1)) ? '0
               : rd_ff + fmtsc_pkg::JOB_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + fmtsc_pkg::JOB_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - fmtsc_pkg::JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Write the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/fmtsc_back.sv =====
`timescale 1ns / 1ps

module fmtsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  fmtsc_pkg::job_type    job_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output fmtsc_pkg::result_type rsp_item
);

   // Sequencer
   logic                             busy_ff, busy_in;
   fmtsc_pkg::job_type               cur_ff, cur_in;
   logic [fmtsc_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic                             produce;
   logic                             in_frame;
   logic                             finish;
   logic                             load;
   fmtsc_pkg::result_type            res;

   // Result queue
   fmtsc_pkg::result_type            res_mem_ff [fmtsc_pkg::RES_DEPTH];
   logic [fmtsc_pkg::RES_PTR_W-1:0]  res_wr_ff, res_wr_in;
   logic [fmtsc_pkg::RES_PTR_W-1:0]  res_rd_ff, res_rd_in;
   logic [fmtsc_pkg::RES_CNT_W-1:0]  res_count_ff, res_count_in;
   logic                             res_pop;

   assign produce   = busy_ff && (res_count_ff != fmtsc_pkg::RES_CNT_W'(fmtsc_pkg::RES_DEPTH));
   assign in_frame  = cur_ff.is_tune && (idx_ff != fmtsc_pkg::CNT_W'(fmtsc_pkg::FRAME_BITS));
   assign finish    = produce && !in_frame;
   assign job_ready = !busy_ff || finish;
   assign load      = job_valid && job_ready;

   // Form the current result: frame bits first, then the closing result
   always_comb begin
      res = '0;
      if (in_frame) begin
         res.kind       = fmtsc_pkg::KIND_BIT;
         res.bit_index  = fmtsc_pkg::IDX_W'(idx_ff);
         res.serial_bit = cur_ff.frame[fmtsc_pkg::FRAME_W-1];
      end else begin
         res.kind            = cur_ff.tail.kind;
         res.volume_code     = cur_ff.tail.vcode;
         res.signal_present  = cur_ff.tail.sig;
         res.stereo_detected = cur_ff.tail.st;
         res.last            = 1'b1;
      end
   end

   // Load a job, or shift the frame and advance the bit counter
   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         cur_in  = job_data;
         idx_in  = '0;
      end else begin
         if (finish) begin
            busy_in = 1'b0;
         end
         if (produce && in_frame) begin
            cur_in.frame = cur_ff.frame << 1;
            idx_in       = idx_ff + fmtsc_pkg::CNT_W'(1);
         end
      end
   end

   // Result queue pointers
   assign rsp_empty = (res_count_ff == '0);
   assign rsp_item  = res_mem_ff[res_rd_ff];
   assign res_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      res_wr_in    = res_wr_ff;
      res_rd_in    = res_rd_ff;
      res_count_in = res_count_ff;
      if (produce) begin
         res_wr_in = (res_wr_ff == fmtsc_pkg::RES_PTR_W'(fmtsc_pkg::RES_DEPTH - 1)) ? '0
                   : res_wr_ff + fmtsc_pkg::RES_PTR_W'(1);
      end
      if (res_pop) begin
         res_rd_in = (res_rd_ff == fmtsc_pkg::RES_PTR_W'(fmtsc_pkg::RES_DEPTH - 1)) ? '0
                   : res_rd_ff + fmtsc_pkg::RES_PTR_W'(1);
      end
      if (produce && !res_pop) begin
         res_count_in = res_count_ff + fmtsc_pkg::RES_CNT_W'(1);
      end else if (res_pop && !produce) begin
         res_count_in = res_count_ff - fmtsc_pkg::RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         res_wr_ff    <= '0;
         res_rd_ff    <= '0;
         res_count_ff <= '0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         res_wr_ff    <= res_wr_in;
         res_rd_ff    <= res_rd_in;
         res_count_ff <= res_count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (produce) begin
         res_mem_ff[res_wr_ff] <= res;
      end
   end

   // A freshly loaded job starts at the first frame bit
   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && (idx_ff == '0)))
      else $error("job load did not restart the bit counter");

   // The bit counter holds while the result queue is full
   a_idx_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !produce && !load) |=> $stable(idx_ff))
      else $error("bit counter moved during a stall");

   // An empty result queue has matching pointers
   a_res_ptrs: assert property (@(posedge clock) disable iff (reset)
      (res_count_ff == '0) |-> (res_rd_ff == res_wr_ff))
      else $error("result queue pointers out of step");

   // A serial bit never closes a job
   a_bit_not_last: assert property (@(posedge clock) disable iff (reset)
      (produce && in_frame) |=> !(res_mem_ff[$past(res_wr_ff)].last))
      else $error("serial bit result marked as last");

endmodule

// ===== hdl/fm_tuner_serial_command_unit.sv =====
`timescale 1ns / 1ps
// Channel   Ports                          Handshake
// -------   -----------------------------  --------------------------------
// request   req_command .. req_status_*    req_push && !req_full
// result    rsp_kind .. rsp_last           rsp_pop && !rsp_empty
//
// A tuning job yields FRAME_BITS + 1 results (46 by default), one per cycle while
// the result queue has room, from the back-end bit sequencer. Other commands
// yield at most one result. The front end takes one item per cycle while
// req_full is low; each item passes through the classify stage and the
// divide-by-160 multiplier stage on its way to the job queue.
// Synchronous reset: volume 0, unmuted, stereo allowed, no stored frequency.
// req_full rises once both front stages and the two-entry job queue are full.

module fm_tuner_serial_command_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [fmtsc_pkg::CMD_W-1:0]   req_command,
   input  logic [fmtsc_pkg::FREQ_W-1:0]  req_frequency,
   input  logic [fmtsc_pkg::VOL_W-1:0]   req_volume,
   input  logic                          req_stereo_mode,
   input  logic [fmtsc_pkg::STAT_W-1:0]  req_status_first,
   input  logic [fmtsc_pkg::STAT_W-1:0]  req_status_second,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [fmtsc_pkg::KIND_W-1:0]  rsp_kind,
   output logic [fmtsc_pkg::IDX_W-1:0]   rsp_bit_index,
   output logic                          rsp_serial_bit,
   output logic [fmtsc_pkg::VOL_W-1:0]   rsp_volume_code,
   output logic                          rsp_signal_present,
   output logic                          rsp_stereo_detected,
   output logic                          rsp_last
);

   logic                   fq_valid;
   logic                   fq_ready;
   fmtsc_pkg::job_type     fq_data;
   logic                   qb_valid;
   logic                   qb_ready;
   fmtsc_pkg::job_type     qb_data;
   fmtsc_pkg::result_type  rsp_item;

   // Accept and classify items
   fmtsc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_frequency     (req_frequency),
      .req_volume        (req_volume),
      .req_stereo_mode   (req_stereo_mode),
      .req_status_first  (req_status_first),
      .req_status_second (req_status_second),
      .job_valid         (fq_valid),
      .job_ready         (fq_ready),
      .job_data          (fq_data)
   );

   // Decouple front and back
   fmtsc_job_queue u_job_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // Emit results
   fmtsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_kind            = rsp_item.kind;
   assign rsp_bit_index       = rsp_item.bit_index;
   assign rsp_serial_bit      = rsp_item.serial_bit;
   assign rsp_volume_code     = rsp_item.volume_code;
   assign rsp_signal_present  = rsp_item.signal_present;
   assign rsp_stereo_detected = rsp_item.stereo_detected;
   assign rsp_last            = rsp_item.last;

endmodule
